// ----- rtl/core/nsg_pkg.sv -----
// ----------------------------------------------------------------------------
// nsg_pkg
// Shared constants and types for the nearest smaller/greater stack core.
// ----------------------------------------------------------------------------
package nsg_pkg;

    localparam int NSG_DATA_W      = 32;
    localparam int NSG_STACK_DEPTH = 256;

    // Search mode codes
    localparam logic NSG_MODE_SMALLER = 1'b0;
    localparam logic NSG_MODE_GREATER = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,    // waiting for an input beat
        ST_CMP,     // compare top of stack, pop or finish
        ST_RD       // refill top-of-stack register from RAM
    } nsg_state_t;

endpackage

// ----- rtl/core/nsg_ram.sv -----
// ----------------------------------------------------------------------------
// nsg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nsg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/nearest_smaller_greater_stack_core.sv -----
// ----------------------------------------------------------------------------
// nearest_smaller_greater_stack_core
// Monotonic-stack engine: nearest earlier strictly smaller/greater value.
// ----------------------------------------------------------------------------
// Steps: an accepted input beat is registered, then compared in ST_CMP. Each
//   pop that leaves entries adds an ST_RD refill of the top-of-stack register
//   from RAM before the next compare; the pop that empties the stack needs no
//   refill. The result register is loaded from ST_CMP once no pop is due.
// Beats: one at a time; every value is pushed and popped at most once. Set by
//   the single stack RAM read port and the shared compare unit. A result
//   waiting in the output register holds the next beat in the compare stage.
// Reset: aresetn (sync, active low) empties the stack, clears mode to 0 and
//   drops m_tvalid. Stack RAM contents are not cleared.
// ----------------------------------------------------------------------------
module nearest_smaller_greater_stack_core
    #(
    parameter int STACK_DEPTH = nsg_pkg::NSG_STACK_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Config: mode (0 = nearest smaller, 1 = nearest greater)
    input  logic                           cfg_we,
    input  logic [0:0]                     cfg_wdata,   // [0] mode
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [nsg_pkg::NSG_DATA_W-1:0] s_tdata,     // [31:0] value
    input  logic [0:0]                     s_tuser,     // [0] start_req
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [nsg_pkg::NSG_DATA_W-1:0] m_tdata,     // [31:0] nearest
    output logic [1:0]                     m_tuser      // [0] found, [1] overflow
);

    import nsg_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    nsg_state_t                    state_reg,  state_next;
    logic [CW-1:0]                 count_reg,  count_next;   // stack fill
    logic signed [NSG_DATA_W-1:0]  top_reg,    top_next;     // cached TOS
    logic signed [NSG_DATA_W-1:0]  val_reg,    val_next;     // current beat
    logic                          mode_reg;

    // Output holding register: frees the input side while a result waits
    logic                          m_valid_reg, m_valid_next;
    logic [NSG_DATA_W-1:0]         m_data_reg,  m_data_next;
    logic                          m_found_reg, m_found_next;
    logic                          m_ovf_reg,   m_ovf_next;

    // RAM port signals
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [NSG_DATA_W-1:0] ram_rdata;

    logic                  qualifies;   // shared compare unit
    logic                  pop;
    logic                  out_free;
    logic [CW-1:0]         count_m2;

    nsg_ram #(
        .WIDTH (NSG_DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (val_reg),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Top of stack survives when strictly beyond the value in search direction
    assign qualifies = (mode_reg == NSG_MODE_GREATER) ? (top_reg > val_reg)
                                                      : (top_reg < val_reg);
    assign pop       = (count_reg != '0) && !qualifies;
    assign out_free  = !m_valid_reg || m_tready;
    assign count_m2  = count_reg - CW'(2);

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = {m_ovf_reg, m_found_reg};

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        top_next     = top_reg;
        val_next     = val_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_found_next = m_found_reg;
        m_ovf_next   = m_ovf_reg;
        ram_we       = 1'b0;
        ram_waddr    = count_reg[AW-1:0];
        ram_re       = 1'b0;
        ram_raddr    = count_m2[AW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    val_next   = s_tdata;
                    if (s_tuser[0]) begin
                        count_next = '0;   // new array: empty the stack
                    end
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (pop) begin
                    count_next = count_reg - CW'(1);
                    if (count_reg > CW'(1)) begin
                        ram_re     = 1'b1;   // fetch new top of stack
                        state_next = ST_RD;
                    end
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_found_next = (count_reg != '0);
                    m_data_next  = (count_reg != '0) ? top_reg : '0;
                    if (count_reg < CW'(STACK_DEPTH)) begin
                        ram_we     = 1'b1;
                        top_next   = val_reg;
                        count_next = count_reg + CW'(1);
                        m_ovf_next = 1'b0;
                    end else begin
                        m_ovf_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_RD: begin
                top_next   = ram_rdata;
                state_next = ST_CMP;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            mode_reg    <= NSG_MODE_SMALLER;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                mode_reg <= cfg_wdata[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        top_reg     <= top_next;
        val_reg     <= val_next;
        m_data_reg  <= m_data_next;
        m_found_reg <= m_found_next;
        m_ovf_reg   <= m_ovf_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_rd_after_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RD |-> $past(state_reg) == ST_CMP)
        else $error("refill without compare");

    a_rd_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RD |-> count_reg != '0)
        else $error("refill on empty stack");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_CMP)
        else $error("result not from compare stage");

endmodule
